// ----- rtl/sljd_pkg.sv -----
// shared types and constants of the sync/length/xor frame deframer
package sljd_pkg;

    // fixed frame layout
    localparam int unsigned FRAME_OVERHEAD = 5;

    // result kinds
    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_EMPTY = 2'd1;
    localparam logic [1:0] KIND_LONG  = 2'd2;
    localparam logic [1:0] KIND_XSUM  = 2'd3;

    // configuration register indexes
    localparam logic [1:0] REG_SYNC_FIRST    = 2'd0;
    localparam logic [1:0] REG_SYNC_SECOND   = 2'd1;
    localparam logic [1:0] REG_PAYLOAD_LIMIT = 2'd2;

    // reset values of the configuration registers
    localparam logic [7:0] SYNC_FIRST_RST    = 8'd170;
    localparam logic [7:0] SYNC_SECOND_RST   = 8'd85;
    localparam logic [7:0] PAYLOAD_LIMIT_RST = 8'd255;

    // read offset updates
    typedef enum logic [2:0] {
        OFF_KEEP,
        OFF_ZERO,
        OFF_INC,
        OFF_TWO,
        OFF_THREE,
        OFF_FOUR
    } off_op_t;

    // buffer front removal
    typedef enum logic [1:0] {
        DROP_NONE,
        DROP_SCAN,
        DROP_FRAME,
        DROP_ONE
    } drop_op_t;

    // controller to datapath commands
    typedef struct packed {
        logic       load;
        off_op_t    off_op;
        drop_op_t   drop_op;
        logic       set_prev;
        logic       set_type;
        logic       set_len;
        logic       sum_init;
        logic       sum_acc;
        logic       idx_clr;
        logic       idx_inc;
        logic       emit;
        logic [1:0] emit_kind;
        logic       flush;
    } dp_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic off_at_count;
        logic pair_hit;
        logic hdr_short;
        logic frame_short;
        logic too_long;
        logic sum_end;
        logic sum_ok;
        logic len_zero;
        logic idx_last;
        logic can_emit;
        logic pend_valid;
        logic out_free;
    } dp_stat_t;

endpackage

// ----- rtl/sljd_ram.sv -----
// generic single-write, single-read ram with registered read data
module sljd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/sljd_ctrl.sv -----
// controller state machine of the frame deframer
module sljd_ctrl
    import sljd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    typedef enum logic [13:0] {
        ST_IDLE   = 14'b00000000000001,
        ST_SCAN_A = 14'b00000000000010,
        ST_SCAN_B = 14'b00000000000100,
        ST_HDR    = 14'b00000000001000,
        ST_TYP_A  = 14'b00000000010000,
        ST_TYP_B  = 14'b00000000100000,
        ST_LEN_A  = 14'b00000001000000,
        ST_LEN_B  = 14'b00000010000000,
        ST_CHK    = 14'b00000100000000,
        ST_SUM_A  = 14'b00001000000000,
        ST_SUM_B  = 14'b00010000000000,
        ST_PAY_A  = 14'b00100000000000,
        ST_PAY_B  = 14'b01000000000000,
        ST_FIN    = 14'b10000000000000
    } state_t;

    state_t state_reg, state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != ST_IDLE);

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        cmd.off_op = OFF_KEEP;
        cmd.drop_op = DROP_NONE;
        cmd.emit_kind = KIND_DATA;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    cmd.off_op = OFF_ZERO;
                    state_next = ST_SCAN_A;
                end
            end
            ST_SCAN_A:
            begin
                if (stat.off_at_count)
                begin
                    // no pair: keep only the newest byte
                    cmd.drop_op = DROP_SCAN;
                    state_next = ST_FIN;
                end
                else
                begin
                    state_next = ST_SCAN_B;
                end
            end
            ST_SCAN_B:
            begin
                if (stat.pair_hit)
                begin
                    cmd.drop_op = DROP_SCAN;
                    state_next = ST_HDR;
                end
                else
                begin
                    cmd.set_prev = 1'b1;
                    cmd.off_op = OFF_INC;
                    state_next = ST_SCAN_A;
                end
            end
            ST_HDR:
            begin
                if (stat.hdr_short)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    cmd.off_op = OFF_TWO;
                    state_next = ST_TYP_A;
                end
            end
            ST_TYP_A:
            begin
                state_next = ST_TYP_B;
            end
            ST_TYP_B:
            begin
                cmd.set_type = 1'b1;
                cmd.off_op = OFF_THREE;
                state_next = ST_LEN_A;
            end
            ST_LEN_A:
            begin
                state_next = ST_LEN_B;
            end
            ST_LEN_B:
            begin
                cmd.set_len = 1'b1;
                state_next = ST_CHK;
            end
            ST_CHK:
            begin
                if (stat.frame_short)
                begin
                    state_next = ST_FIN;
                end
                else if (stat.too_long)
                begin
                    if (stat.can_emit)
                    begin
                        cmd.emit = 1'b1;
                        cmd.emit_kind = KIND_LONG;
                        cmd.drop_op = DROP_FRAME;
                        cmd.off_op = OFF_ZERO;
                        state_next = ST_SCAN_A;
                    end
                end
                else
                begin
                    cmd.sum_init = 1'b1;
                    cmd.off_op = OFF_FOUR;
                    state_next = ST_SUM_A;
                end
            end
            ST_SUM_A:
            begin
                state_next = ST_SUM_B;
            end
            ST_SUM_B:
            begin
                if (!stat.sum_end)
                begin
                    cmd.sum_acc = 1'b1;
                    cmd.off_op = OFF_INC;
                    state_next = ST_SUM_A;
                end
                else if (!stat.sum_ok)
                begin
                    if (stat.can_emit)
                    begin
                        cmd.emit = 1'b1;
                        cmd.emit_kind = KIND_XSUM;
                        cmd.drop_op = DROP_ONE;
                        cmd.off_op = OFF_ZERO;
                        state_next = ST_SCAN_A;
                    end
                end
                else if (stat.len_zero)
                begin
                    if (stat.can_emit)
                    begin
                        cmd.emit = 1'b1;
                        cmd.emit_kind = KIND_EMPTY;
                        cmd.drop_op = DROP_FRAME;
                        cmd.off_op = OFF_ZERO;
                        state_next = ST_SCAN_A;
                    end
                end
                else
                begin
                    cmd.idx_clr = 1'b1;
                    cmd.off_op = OFF_FOUR;
                    state_next = ST_PAY_A;
                end
            end
            ST_PAY_A:
            begin
                state_next = ST_PAY_B;
            end
            ST_PAY_B:
            begin
                if (stat.can_emit)
                begin
                    cmd.emit = 1'b1;
                    cmd.emit_kind = KIND_DATA;
                    if (stat.idx_last)
                    begin
                        cmd.drop_op = DROP_FRAME;
                        cmd.off_op = OFF_ZERO;
                        state_next = ST_SCAN_A;
                    end
                    else
                    begin
                        cmd.idx_inc = 1'b1;
                        cmd.off_op = OFF_INC;
                        state_next = ST_PAY_A;
                    end
                end
            end
            ST_FIN:
            begin
                // release the held result marked as final
                if (!stat.pend_valid)
                begin
                    state_next = ST_IDLE;
                end
                else if (stat.out_free)
                begin
                    cmd.flush = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/sljd_dp.sv -----
// datapath of the frame deframer: ring buffer pointers, scan, checksum, results
module sljd_dp
    import sljd_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  dp_cmd_t                  cmd,
    output dp_stat_t                 stat,
    input  logic [7:0]               rx_byte,
    input  logic [7:0]               sync_first,
    input  logic [7:0]               sync_second,
    input  logic [7:0]               payload_limit,
    output logic                     ram_we,
    output logic [$clog2(DEPTH)-1:0] ram_waddr,
    output logic [7:0]               ram_wdata,
    output logic [$clog2(DEPTH)-1:0] ram_raddr,
    input  logic [7:0]               ram_rdata,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [1:0]               kind,
    output logic [7:0]               frame_type,
    output logic [7:0]               data_byte,
    output logic [7:0]               byte_index,
    output logic [7:0]               payload_length,
    output logic                     last
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;
    localparam logic [SW-1:0] DEPTH_S = SW'(DEPTH);

    // ring position of head plus an offset no larger than the depth
    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                               input logic [CW-1:0] n);
        logic [SW-1:0] s;
        s = SW'(base) + SW'(n);
        if (s >= DEPTH_S)
        begin
            s = s - DEPTH_S;
        end
        return s[AW-1:0];
    endfunction

    logic [AW-1:0] head_reg, head_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] off_reg, off_next;
    logic [7:0]    prev_reg, type_reg, len_reg, sum_reg, idx_reg;
    logic [CW-1:0] drop_n;
    logic [8:0]    flen;

    logic          pend_valid_reg;
    logic [1:0]    pend_kind_reg;
    logic [7:0]    pend_type_reg, pend_data_reg, pend_idx_reg, pend_len_reg;

    logic          out_valid_reg;
    logic [1:0]    out_kind_reg;
    logic [7:0]    out_type_reg, out_data_reg, out_idx_reg, out_len_reg;
    logic          out_last_reg;
    logic          out_free, push;

    assign flen = 9'(FRAME_OVERHEAD) + 9'(len_reg);

    // buffer ports
    assign ram_we    = cmd.load;
    assign ram_waddr = wrap_add(head_reg, count_reg);
    assign ram_wdata = rx_byte;
    assign ram_raddr = wrap_add(head_reg, off_reg);

    // amount removed from the front
    always_comb
    begin
        case (cmd.drop_op)
            DROP_SCAN:  drop_n = (off_reg == '0) ? '0 : off_reg - CW'(1);
            DROP_FRAME: drop_n = flen[CW-1:0];
            DROP_ONE:   drop_n = CW'(1);
            default:    drop_n = '0;
        endcase
    end

    // head and fill count
    always_comb
    begin
        head_next = head_reg;
        count_next = count_reg;
        if (cmd.load)
        begin
            if (count_reg == CW'(DEPTH))
            begin
                head_next = wrap_add(head_reg, CW'(1));
            end
            else
            begin
                count_next = count_reg + CW'(1);
            end
        end
        else if (cmd.drop_op != DROP_NONE)
        begin
            head_next = wrap_add(head_reg, drop_n);
            count_next = count_reg - drop_n;
        end
    end

    // read offset
    always_comb
    begin
        case (cmd.off_op)
            OFF_ZERO:  off_next = '0;
            OFF_INC:   off_next = off_reg + CW'(1);
            OFF_TWO:   off_next = CW'(2);
            OFF_THREE: off_next = CW'(3);
            OFF_FOUR:  off_next = CW'(4);
            default:   off_next = off_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg <= head_next;
            count_reg <= count_next;
        end
    end

    // scan and frame registers
    always_ff @(posedge clk)
    begin
        off_reg <= off_next;
        if (cmd.set_prev)
        begin
            prev_reg <= ram_rdata;
        end
        if (cmd.set_type)
        begin
            type_reg <= ram_rdata;
        end
        if (cmd.set_len)
        begin
            len_reg <= ram_rdata;
        end
        if (cmd.sum_init)
        begin
            sum_reg <= type_reg ^ len_reg;
        end
        else if (cmd.sum_acc)
        begin
            sum_reg <= sum_reg ^ ram_rdata;
        end
        if (cmd.idx_clr)
        begin
            idx_reg <= '0;
        end
        else if (cmd.idx_inc)
        begin
            idx_reg <= idx_reg + 8'd1;
        end
    end

    // output slot and held result
    assign out_free = !out_valid_reg || !out_stall;
    assign push = (cmd.emit && pend_valid_reg) || cmd.flush;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.emit)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (cmd.flush)
            begin
                pend_valid_reg <= 1'b0;
            end
            if (push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            pend_kind_reg <= cmd.emit_kind;
            pend_type_reg <= type_reg;
            pend_len_reg  <= len_reg;
            pend_data_reg <= (cmd.emit_kind == KIND_DATA) ? ram_rdata : 8'd0;
            pend_idx_reg  <= (cmd.emit_kind == KIND_DATA) ? idx_reg : 8'd0;
        end
        if (push)
        begin
            out_kind_reg <= pend_kind_reg;
            out_type_reg <= pend_type_reg;
            out_data_reg <= pend_data_reg;
            out_idx_reg  <= pend_idx_reg;
            out_len_reg  <= pend_len_reg;
            out_last_reg <= cmd.flush;
        end
    end

    assign out_valid      = out_valid_reg;
    assign kind           = out_kind_reg;
    assign frame_type     = out_type_reg;
    assign data_byte      = out_data_reg;
    assign byte_index     = out_idx_reg;
    assign payload_length = out_len_reg;
    assign last           = out_last_reg;

    // status
    assign stat.off_at_count = (off_reg == count_reg);
    assign stat.pair_hit     = (off_reg != '0) && (prev_reg == sync_first)
                               && (ram_rdata == sync_second);
    assign stat.hdr_short    = (count_reg < CW'(FRAME_OVERHEAD));
    assign stat.frame_short  = (9'(count_reg) < flen);
    assign stat.too_long     = (len_reg > payload_limit);
    assign stat.sum_end      = (9'(off_reg) == (9'd4 + 9'(len_reg)));
    assign stat.sum_ok       = (sum_reg == ram_rdata);
    assign stat.len_zero     = (len_reg == 8'd0);
    assign stat.idx_last     = (idx_reg == (len_reg - 8'd1));
    assign stat.can_emit     = !pend_valid_reg || out_free;
    assign stat.pend_valid   = pend_valid_reg;
    assign stat.out_free     = out_free;

endmodule

// ----- rtl/sync_len_xor_frame_deframer.sv -----
// top level of the sync/length/xor frame deframer
//
//  channel  | handshake              | payload
//  ---------+------------------------+------------------------------------------------
//  in       | in_valid / in_stall    | rx_byte
//  out      | out_valid / out_stall  | kind frame_type data_byte byte_index
//           |                        | payload_length last
//  config   | psel penable pwrite    | paddr pwdata prdata
//
//  after each word the bytes up to the sync pair are scanned and the frame bytes
//  read, all through the single read port of the ring buffer ram, whose read
//  data is registered; the input stalls until the controller is idle again.
//  reset clears the fill count and the handshakes; buffer contents need none.
//  a stalled output holds one result and a second waits in a holding register
//  before the scan pauses.
module sync_len_xor_frame_deframer
    import sljd_pkg::*;
#(
    parameter int BUFFER_DEPTH = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  kind,
    output logic [7:0]  frame_type,
    output logic [7:0]  data_byte,
    output logic [7:0]  byte_index,
    output logic [7:0]  payload_length,
    output logic        last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW = $clog2(BUFFER_DEPTH);

    logic [7:0] sync_first_reg, sync_second_reg, payload_limit_reg;
    logic       cfg_write;
    dp_cmd_t    cmd;
    dp_stat_t   stat;
    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [7:0]    ram_wdata, ram_rdata;

    // configuration registers
    assign pready = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_first_reg <= SYNC_FIRST_RST;
            sync_second_reg <= SYNC_SECOND_RST;
            payload_limit_reg <= PAYLOAD_LIMIT_RST;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                REG_SYNC_FIRST:    sync_first_reg <= pwdata[7:0];
                REG_SYNC_SECOND:   sync_second_reg <= pwdata[7:0];
                REG_PAYLOAD_LIMIT: payload_limit_reg <= pwdata[7:0];
                default:           ;
            endcase
        end
    end

    // register read back
    always_comb
    begin
        case (paddr[3:2])
            REG_SYNC_FIRST:    prdata = {24'd0, sync_first_reg};
            REG_SYNC_SECOND:   prdata = {24'd0, sync_second_reg};
            REG_PAYLOAD_LIMIT: prdata = {24'd0, payload_limit_reg};
            default:           prdata = '0;
        endcase
    end

    sljd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    sljd_dp #(
        .DEPTH (BUFFER_DEPTH)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .rx_byte        (rx_byte),
        .sync_first     (sync_first_reg),
        .sync_second    (sync_second_reg),
        .payload_limit  (payload_limit_reg),
        .ram_we         (ram_we),
        .ram_waddr      (ram_waddr),
        .ram_wdata      (ram_wdata),
        .ram_raddr      (ram_raddr),
        .ram_rdata      (ram_rdata),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .kind           (kind),
        .frame_type     (frame_type),
        .data_byte      (data_byte),
        .byte_index     (byte_index),
        .payload_length (payload_length),
        .last           (last)
    );

    sljd_ram #(
        .WIDTH (8),
        .DEPTH (BUFFER_DEPTH)
    ) u_buf (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule

// ----- rtl/sljd_checker.sv -----
// port checks of the frame deframer and their binding
module sljd_checker
    import sljd_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic [1:0] kind,
    input logic [7:0] data_byte,
    input logic [7:0] byte_index,
    input logic [7:0] payload_length,
    input logic       last
);

    // a stalled word stays
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("output word dropped while stalled");

    // a stalled word keeps its final mark
    a_last_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(last))
        else $error("final mark changed while stalled");

    // only payload words carry data and an index
    a_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind != KIND_DATA |-> data_byte == 8'd0 && byte_index == 8'd0)
        else $error("non-payload word carries data");

    // an empty frame has length zero, a payload word an index inside the length
    a_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (kind != KIND_EMPTY || payload_length == 8'd0)
                   && (kind != KIND_DATA || byte_index < payload_length))
        else $error("length field inconsistent with word kind");

endmodule

bind sync_len_xor_frame_deframer sljd_checker u_sljd_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .kind           (kind),
    .data_byte      (data_byte),
    .byte_index     (byte_index),
    .payload_length (payload_length),
    .last           (last)
);

// ----- sim/sync_len_xor_frame_deframer_tb.sv -----
// testbench of the sync/length/xor frame deframer
`timescale 1ns / 100ps

module sync_len_xor_frame_deframer_tb;
    import sljd_pkg::*;

    localparam int DEPTH = 64;
    localparam int MAX_OUT = 64;
    localparam int CYCLE_LIMIT = 2000000;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] frame_type;
        logic [7:0] data_byte;
        logic [7:0] byte_index;
        logic [7:0] payload_length;
        logic       last;
    } frame_res_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  rx_byte;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  kind;
    logic [7:0]  frame_type;
    logic [7:0]  data_byte;
    logic [7:0]  byte_index;
    logic [7:0]  payload_length;
    logic        last;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    sync_len_xor_frame_deframer #(.BUFFER_DEPTH(DEPTH)) uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .rx_byte(rx_byte),
        .out_valid(out_valid), .out_stall(out_stall), .kind(kind),
        .frame_type(frame_type), .data_byte(data_byte), .byte_index(byte_index),
        .payload_length(payload_length), .last(last),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // predictor state
    logic [7:0] held_bytes[DEPTH];
    int         held_count;
    logic [7:0] cfg_first;
    logic [7:0] cfg_second;
    logic [7:0] cfg_limit;

    frame_res_t expected_q[$];
    int         fail_count;
    int         cycle_count;
    int         results_seen;
    int         sent_count;
    logic       rx_hold;
    logic       out_idle_free;
    int         long_hold;
    logic       hold_used;

    // clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic void shed_front(int n);
        if (n > held_count)
            n = held_count;
        for (int k = 0; k + n < held_count; k++)
            held_bytes[k] = held_bytes[k + n];
        held_count -= n;
    endfunction

    function automatic frame_res_t make_res(logic [1:0] kd, logic [7:0] ty,
                                            logic [7:0] db, logic [7:0] ix,
                                            logic [7:0] pl);
        frame_res_t r;
        r.kind = kd;
        r.frame_type = ty;
        r.data_byte = db;
        r.byte_index = ix;
        r.payload_length = pl;
        r.last = 1'b0;
        return r;
    endfunction

    // expected results of one received byte
    function automatic void deframe_byte(logic [7:0] b);
        int idx;
        int plen;
        int flen;
        int produced;
        logic [7:0] ty;
        logic [7:0] xsum;
        produced = 0;
        if (held_count >= DEPTH)
            shed_front(held_count - DEPTH + 1);
        held_bytes[held_count] = b;
        held_count++;
        forever
        begin
            idx = 0;
            while (idx + 1 < held_count &&
                   !(held_bytes[idx] == cfg_first && held_bytes[idx + 1] == cfg_second))
                idx++;
            if (idx > 0)
                shed_front(idx);
            if (held_count < FRAME_OVERHEAD)
                break;
            ty = held_bytes[2];
            plen = int'(held_bytes[3]);
            flen = FRAME_OVERHEAD + plen;
            if (held_count < flen || produced >= MAX_OUT)
                break;
            if (plen > cfg_limit)
            begin
                expected_q.push_back(make_res(KIND_LONG, ty, 8'd0, 8'd0, 8'(plen)));
                produced++;
                shed_front(flen);
                continue;
            end
            xsum = ty ^ plen[7:0];
            for (int k = 0; k < plen; k++)
                xsum ^= held_bytes[4 + k];
            if (xsum != held_bytes[4 + plen])
            begin
                expected_q.push_back(make_res(KIND_XSUM, ty, 8'd0, 8'd0, 8'(plen)));
                produced++;
                shed_front(1);
                continue;
            end
            if (plen == 0)
            begin
                expected_q.push_back(make_res(KIND_EMPTY, ty, 8'd0, 8'd0, 8'd0));
                produced++;
            end
            else
            begin
                for (int k = 0; k < plen && produced < MAX_OUT; k++)
                begin
                    expected_q.push_back(make_res(KIND_DATA, ty, held_bytes[4 + k],
                                                  8'(k), 8'(plen)));
                    produced++;
                end
            end
            shed_front(flen);
        end
        if (produced > 0)
            expected_q[$].last = 1'b1;
    endfunction

    // result checker
    always @(posedge clk)
    begin
        frame_res_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (expected_q.size() == 0)
            begin
                $error("unexpected result word kind=%0d", kind);
                fail_count++;
            end
            else
            begin
                want = expected_q.pop_front();
                if (kind !== want.kind)
                begin
                    $error("kind: expected %0d actual %0d", want.kind, kind);
                    fail_count++;
                end
                if (frame_type !== want.frame_type)
                begin
                    $error("frame_type: expected %0h actual %0h", want.frame_type, frame_type);
                    fail_count++;
                end
                if (data_byte !== want.data_byte)
                begin
                    $error("data_byte: expected %0h actual %0h", want.data_byte, data_byte);
                    fail_count++;
                end
                if (byte_index !== want.byte_index)
                begin
                    $error("byte_index: expected %0d actual %0d", want.byte_index, byte_index);
                    fail_count++;
                end
                if (payload_length !== want.payload_length)
                begin
                    $error("payload_length: expected %0d actual %0d",
                           want.payload_length, payload_length);
                    fail_count++;
                end
                if (last !== want.last)
                begin
                    $error("last: expected %0d actual %0d", want.last, last);
                    fail_count++;
                end
            end
        end
    end

    // receiver stall pattern, with one long hold-off when the sender starts its burst
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            long_hold <= 0;
            hold_used <= 1'b0;
        end
        else if (rx_hold && !hold_used)
        begin
            out_stall <= 1'b1;
            long_hold <= 300;
            hold_used <= 1'b1;
        end
        else if (long_hold > 0)
        begin
            out_stall <= 1'b1;
            long_hold <= long_hold - 1;
        end
        else if (out_idle_free)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(99) < 23);
    end

    task automatic apb_write(logic [1:0] reg_idx, logic [7:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {reg_idx, 2'b00};
        pwdata <= {24'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (reg_idx)
            REG_SYNC_FIRST:  cfg_first = value;
            REG_SYNC_SECOND: cfg_second = value;
            default:         cfg_limit = value;
        endcase
    endtask

    // send one word; the predictor runs at acceptance
    task automatic send_byte(logic [7:0] b);
        while (!rx_hold && $urandom_range(99) < 23)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        deframe_byte(b);
        sent_count++;
    endtask

    // wait until the block has delivered every expected result and gone quiet
    task automatic drain();
        in_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (600) @(posedge clk);
    endtask

    task automatic send_frame(logic [7:0] ty, int len, bit bad_sum, int cap);
        logic [7:0] xs;
        logic [7:0] pb;
        xs = ty ^ len[7:0];
        send_byte(cfg_first);
        send_byte(cfg_second);
        send_byte(ty);
        send_byte(len[7:0]);
        for (int k = 0; k < len && k < cap; k++)
        begin
            pb = 8'($urandom_range(255));
            xs ^= pb;
            send_byte(pb);
        end
        send_byte(bad_sum ? ~xs : xs);
    endtask

    // directed words: byte plus optional typed-in kind of the newest predicted result
    typedef struct {
        logic [7:0] b;
        bit         has_exp;
        logic [1:0] exp_kind;
    } dir_row_t;

    dir_row_t dir_rows[$];

    initial
    begin
        frame_res_t first_exp;
        int n_items;
        int kind_pick;
        bit burst_done;
        bit pause_done;
        fail_count = 0;
        results_seen = 0;
        sent_count = 0;
        out_idle_free = 1'b0;
        rx_hold = 1'b0;
        held_count = 0;
        cfg_first = SYNC_FIRST_RST;
        cfg_second = SYNC_SECOND_RST;
        cfg_limit = PAYLOAD_LIMIT_RST;
        rst_n = 1'b0;
        in_valid = 1'b0;
        rx_byte = 8'd0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = 4'd0;
        pwdata = 32'd0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty good frame, checksum error, one-byte frame, noise
        dir_rows = '{
            '{8'h00, 0, KIND_DATA}, '{8'hFF, 0, KIND_DATA},
            '{8'hAA, 0, KIND_DATA}, '{8'h55, 0, KIND_DATA}, '{8'h7E, 0, KIND_DATA},
            '{8'h00, 0, KIND_DATA}, '{8'h7E, 1, KIND_EMPTY},
            '{8'hAA, 0, KIND_DATA}, '{8'h55, 0, KIND_DATA}, '{8'h01, 0, KIND_DATA},
            '{8'h00, 0, KIND_DATA}, '{8'h00, 1, KIND_XSUM},
            '{8'hAA, 0, KIND_DATA}, '{8'h55, 0, KIND_DATA}, '{8'hFF, 0, KIND_DATA},
            '{8'h01, 0, KIND_DATA}, '{8'hFF, 0, KIND_DATA}, '{8'h01, 1, KIND_DATA},
            '{8'hAA, 0, KIND_DATA}, '{8'hAA, 0, KIND_DATA}, '{8'h55, 0, KIND_DATA}
        };
        foreach (dir_rows[i])
        begin
            send_byte(dir_rows[i].b);
            if (dir_rows[i].has_exp)
            begin
                first_exp = expected_q[$];
                if (first_exp.kind !== dir_rows[i].exp_kind)
                begin
                    $error("kind: expected %0d actual %0d", dir_rows[i].exp_kind,
                           first_exp.kind);
                    fail_count++;
                end
            end
        end
        drain();

        // too long frame against a zero limit, new sync markers
        apb_write(REG_PAYLOAD_LIMIT, 8'd0);
        apb_write(REG_SYNC_FIRST, 8'h00);
        apb_write(REG_SYNC_SECOND, 8'hFF);
        send_frame(8'h3C, 2, 0, 255);
        send_frame(8'hC3, 0, 0, 255);
        drain();
        apb_write(REG_PAYLOAD_LIMIT, 8'd255);
        apb_write(REG_SYNC_FIRST, 8'hFF);
        apb_write(REG_SYNC_SECOND, 8'hFF);
        // oversize frame cannot complete; it is shed as bytes arrive
        send_frame(8'h11, 200, 0, 70);
        for (int k = 0; k < 5; k++)
            send_byte(8'($urandom_range(255)));
        drain();

        // random phases over several register settings
        n_items = sent_count;
        burst_done = 1'b0;
        pause_done = 1'b0;
        for (int phase = 0; phase < 4; phase++)
        begin
            apb_write(REG_SYNC_FIRST, 8'($urandom_range(255)));
            apb_write(REG_SYNC_SECOND, 8'($urandom_range(255)));
            apb_write(REG_PAYLOAD_LIMIT, phase == 0 ? 8'd255 :
                      (phase == 1 ? 8'd3 : 8'($urandom_range(60))));
            out_idle_free = (phase == 2);
            while (sent_count < n_items + (phase + 1) * 75)
            begin
                kind_pick = $urandom_range(99);
                if (kind_pick < 60)
                    send_frame(8'($urandom_range(255)), $urandom_range(12), 0, 255);
                else if (kind_pick < 70)
                    send_frame(8'($urandom_range(255)), $urandom_range(12), 1, 255);
                else if (kind_pick < 75)
                    send_frame(8'($urandom_range(255)), $urandom_range(40, 58), 0, 255);
                else
                    send_byte(8'($urandom_range(255)));
                if (phase == 1 && !burst_done && sent_count > n_items + 100)
                begin
                    // receiver holds off while the sender keeps going
                    burst_done = 1'b1;
                    rx_hold = 1'b1;
                    for (int k = 0; k < 12; k++)
                        send_frame(8'($urandom_range(255)), $urandom_range(3), 0, 255);
                    rx_hold = 1'b0;
                end
                if (phase == 3 && !pause_done && sent_count > n_items + 260)
                begin
                    pause_done = 1'b1;
                    in_valid <= 1'b0;
                    while (expected_q.size() != 0)
                        @(posedge clk);
                end
            end
            out_idle_free = 1'b0;
            drain();
        end

        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // pready always high on the block; nothing else to watch here
endmodule
